FILE: rtl/comb_table_dfa_scanner_defines.svh
// Assertion macros shared by the DFA scanner checker.
`ifndef COMB_TABLE_DFA_SCANNER_DEFINES_SVH
`define COMB_TABLE_DFA_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CDFA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CDFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cdfa_pkg.sv
// Package: sizes, codes and interface structs of the comb-table DFA scanner.
package cdfa_pkg;

    // Store sizes
    localparam int NUM_STATES  = 256;
    localparam int TABLE_DEPTH = 4096;
    localparam int LINE_DEPTH  = 256;

    // Field and word widths
    localparam int ADDR_W   = 12;
    localparam int VALUE_W  = 16;
    localparam int BASE_W   = 16;
    localparam int ENTRY_W  = 8;
    localparam int CHAR_W   = 16;
    localparam int ID_W     = 8;
    localparam int START_W  = 8;

    // Derived index widths
    localparam int STATE_AW = $clog2(NUM_STATES);
    localparam int TAB_AW   = $clog2(TABLE_DEPTH);
    localparam int LINE_AW  = $clog2(LINE_DEPTH);
    localparam int POS_W    = $clog2(LINE_DEPTH + 1);
    localparam int HOP_W    = $clog2(NUM_STATES + 1);
    localparam int ADD_W    = (BASE_W > CHAR_W) ? BASE_W : CHAR_W;

    localparam logic [CHAR_W-1:0] SPACE_CODE = CHAR_W'(32);

    // Input operation codes
    typedef enum logic [1:0] {
        OP_WR_TABLE = 2'd0,
        OP_WR_LINE  = 2'd1,
        OP_SET_POS  = 2'd2,
        OP_SCAN     = 2'd3
    } cdfa_op_t;

    // Table selectors
    typedef enum logic [2:0] {
        SEL_BASE    = 3'd0,
        SEL_CHECK   = 3'd1,
        SEL_NEXT    = 3'd2,
        SEL_DEFAULT = 3'd3,
        SEL_ACCEPT  = 3'd4
    } cdfa_sel_t;

    // Scan sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SKIP_RD,
        S_SKIP_CHK,
        S_LOOK,
        S_ADDR,
        S_CHK,
        S_ACC,
        S_FIN
    } cdfa_state_t;

    // Sequencer read requests to the table memories
    typedef struct packed {
        logic                line_re;
        logic [LINE_AW-1:0]  line_addr;
        logic                state_re;
        logic [STATE_AW-1:0] state_addr;
        logic                tab_re;
        logic [TAB_AW-1:0]   tab_addr;
        logic                acc_re;
        logic [STATE_AW-1:0] acc_addr;
    } cdfa_rd_req_t;

    // Registered read data returned from the memories
    typedef struct packed {
        logic [CHAR_W-1:0]  line;
        logic [BASE_W-1:0]  base;
        logic [ENTRY_W-1:0] check;
        logic [ENTRY_W-1:0] nxt;
        logic [ENTRY_W-1:0] dflt;
        logic [ENTRY_W-1:0] acc;
    } cdfa_rd_data_t;

    // One scan result
    typedef struct packed {
        logic               found;
        logic [ID_W-1:0]    id;
        logic [START_W-1:0] start;
        logic [POS_W-1:0]   length;
        logic [POS_W-1:0]   resume;
    } cdfa_result_t;

endpackage

FILE: rtl/cdfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cdfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/cdfa_seq.sv
// Scan sequencer: space skip and DFA walk around one shared adder.
module cdfa_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            scan_start,
    input  logic                            pos_we,
    input  logic [cdfa_pkg::VALUE_W-1:0]    pos_value,
    input  cdfa_pkg::cdfa_rd_data_t         rd,
    input  logic                            res_ack,
    output logic                            idle,
    output cdfa_pkg::cdfa_rd_req_t          req,
    output logic                            res_valid,
    output cdfa_pkg::cdfa_result_t          res
);

    localparam int PW  = cdfa_pkg::POS_W;
    localparam int SW  = cdfa_pkg::STATE_AW;
    localparam int AW  = cdfa_pkg::ADD_W;
    localparam int HW  = cdfa_pkg::HOP_W;

    cdfa_pkg::cdfa_state_t state_reg, state_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [PW-1:0]  start_reg, start_next;
    logic [PW-1:0]  last_reg, last_next;
    logic [PW-1:0]  scan_pos_reg, scan_pos_next;
    logic [SW-1:0]  st_reg, st_next;
    logic [HW-1:0]  hops_reg, hops_next;
    logic [cdfa_pkg::ID_W-1:0] id_reg, id_next;
    logic           found_reg, found_next;
    logic           inrange_reg, inrange_next;
    cdfa_pkg::cdfa_result_t res_reg, res_next;

    logic [AW-1:0]  add_a;
    logic [AW-1:0]  add_b;
    logic [AW:0]    add_sum;
    logic           pos_in_line;
    logic           hit;

    // Shared adder: position step, base + char, start + 1
    always_comb
    begin
        add_b = AW'(1);
        unique case (state_reg)
            cdfa_pkg::S_ADDR:
            begin
                add_a = AW'(rd.base);
                add_b = AW'(rd.line);
            end
            cdfa_pkg::S_FIN:
            begin
                add_a = AW'(start_reg);
            end
            default:
            begin
                add_a = AW'(pos_reg);
            end
        endcase
    end

    assign add_sum     = {1'b0, add_a} + {1'b0, add_b};
    assign pos_in_line = pos_reg < PW'(cdfa_pkg::LINE_DEPTH);
    assign hit         = inrange_reg && (rd.check == st_reg);

    // Sequencer state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cdfa_pkg::S_IDLE;
            scan_pos_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_pos_reg <= scan_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        start_reg   <= start_next;
        last_reg    <= last_next;
        st_reg      <= st_next;
        hops_reg    <= hops_next;
        id_reg      <= id_next;
        found_reg   <= found_next;
        inrange_reg <= inrange_next;
        res_reg     <= res_next;
    end

    // Next state, read requests and datapath updates
    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;
        last_next     = last_reg;
        scan_pos_next = scan_pos_reg;
        st_next       = st_reg;
        hops_next     = hops_reg;
        id_next       = id_reg;
        found_next    = found_reg;
        inrange_next  = inrange_reg;
        res_next      = res_reg;
        req           = '0;
        res_valid     = 1'b0;

        unique case (state_reg)
            cdfa_pkg::S_IDLE:
            begin
                if (pos_we)
                begin
                    if ({1'b0, pos_value} > (cdfa_pkg::VALUE_W + 1)'(cdfa_pkg::LINE_DEPTH))
                    begin
                        scan_pos_next = PW'(cdfa_pkg::LINE_DEPTH);
                    end
                    else
                    begin
                        scan_pos_next = pos_value[PW-1:0];
                    end
                end
                if (scan_start)
                begin
                    pos_next   = scan_pos_reg;
                    state_next = cdfa_pkg::S_SKIP_RD;
                end
            end

            cdfa_pkg::S_SKIP_RD:
            begin
                if (pos_in_line)
                begin
                    req.line_re   = 1'b1;
                    req.line_addr = pos_reg[cdfa_pkg::LINE_AW-1:0];
                    state_next    = cdfa_pkg::S_SKIP_CHK;
                end
                else
                begin
                    start_next = pos_reg;
                    last_next  = pos_reg;
                    st_next    = SW'(1);
                    hops_next  = '0;
                    id_next    = '0;
                    found_next = 1'b0;
                    state_next = cdfa_pkg::S_LOOK;
                end
            end

            cdfa_pkg::S_SKIP_CHK:
            begin
                if (rd.line == cdfa_pkg::SPACE_CODE)
                begin
                    pos_next   = add_sum[PW-1:0];
                    state_next = cdfa_pkg::S_SKIP_RD;
                end
                else
                begin
                    start_next = pos_reg;
                    last_next  = pos_reg;
                    st_next    = SW'(1);
                    hops_next  = '0;
                    id_next    = '0;
                    found_next = 1'b0;
                    state_next = cdfa_pkg::S_LOOK;
                end
            end

            // Fetch the character and this state's base and default
            cdfa_pkg::S_LOOK:
            begin
                req.line_re    = 1'b1;
                req.line_addr  = pos_reg[cdfa_pkg::LINE_AW-1:0];
                req.state_re   = 1'b1;
                req.state_addr = st_reg;
                state_next     = cdfa_pkg::S_ADDR;
            end

            // base + char; fetch check and next at that slot
            cdfa_pkg::S_ADDR:
            begin
                inrange_next = pos_in_line &&
                               (add_sum < (AW + 1)'(cdfa_pkg::TABLE_DEPTH));
                req.tab_re   = 1'b1;
                req.tab_addr = add_sum[cdfa_pkg::TAB_AW-1:0];
                state_next   = cdfa_pkg::S_CHK;
            end

            // Transition on check match, else default hop, else stop
            cdfa_pkg::S_CHK:
            begin
                if (hit)
                begin
                    st_next      = rd.nxt;
                    req.acc_re   = 1'b1;
                    req.acc_addr = rd.nxt;
                    state_next   = cdfa_pkg::S_ACC;
                end
                else if ((rd.dflt != '0) && (hops_reg < HW'(cdfa_pkg::NUM_STATES)))
                begin
                    st_next    = rd.dflt;
                    hops_next  = hops_reg + HW'(1);
                    state_next = cdfa_pkg::S_LOOK;
                end
                else
                begin
                    state_next = cdfa_pkg::S_FIN;
                end
            end

            // Record an accepting state and consume the character
            cdfa_pkg::S_ACC:
            begin
                if (rd.acc != '0)
                begin
                    id_next    = rd.acc;
                    found_next = 1'b1;
                    last_next  = pos_reg;
                end
                pos_next   = add_sum[PW-1:0];
                hops_next  = '0;
                state_next = cdfa_pkg::S_LOOK;
            end

            // Hold the result until the output stage takes it
            cdfa_pkg::S_FIN:
            begin
                res_valid         = 1'b1;
                res_next.found    = found_reg;
                res_next.id       = id_reg;
                res_next.start    = start_reg[cdfa_pkg::START_W-1:0];
                res_next.length   = last_reg - start_reg + PW'(1);
                if (found_reg)
                begin
                    res_next.resume = pos_reg;
                end
                else if (add_sum > (AW + 1)'(cdfa_pkg::LINE_DEPTH))
                begin
                    res_next.resume = PW'(cdfa_pkg::LINE_DEPTH);
                end
                else
                begin
                    res_next.resume = add_sum[PW-1:0];
                end
                if (res_ack)
                begin
                    scan_pos_next = res_next.resume;
                    state_next    = cdfa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = cdfa_pkg::S_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == cdfa_pkg::S_IDLE);
    assign res  = res_next;

endmodule

FILE: rtl/comb_table_dfa_scanner.sv
// Top level of the comb-table DFA scanner: memories, sequencer, output register.
// Writes and position sets leave s_tready high after them.
// A scan keeps s_tready low while it skips spaces, consumes characters and follows
// default hops; m_tvalid rises as it ends.
// The finish waits only while an earlier result is still stalled in the output register.
// Reset (rst_n low, async) clears the sequencer, output valid and scan position only.
module comb_table_dfa_scanner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // address[11:0], value[27:12], zero pad
    input  logic [4:0]  s_tuser,   // op[1:0], table_select[4:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // token_id[7:0], token_start[15:8],
                                   // token_length[24:16], resume_position[33:25], pad
    output logic [0:0]  m_tuser    // token_found
);

    cdfa_pkg::cdfa_op_t  op;
    cdfa_pkg::cdfa_sel_t sel;
    logic [cdfa_pkg::ADDR_W-1:0]  address;
    logic [cdfa_pkg::VALUE_W-1:0] value;
    logic in_xfer;
    logic tab_wr;
    logic addr_in_states;
    logic addr_in_table;
    logic addr_in_line;
    logic base_we, check_we, next_we, dflt_we, acc_we, line_we;

    cdfa_pkg::cdfa_rd_req_t  req;
    cdfa_pkg::cdfa_rd_data_t rd;
    cdfa_pkg::cdfa_result_t  res;
    cdfa_pkg::cdfa_result_t  out_reg;
    logic res_valid;
    logic res_ack;
    logic seq_idle;
    logic out_valid_reg;

    // Unpack input transfer
    assign op      = cdfa_pkg::cdfa_op_t'(s_tuser[1:0]);
    assign sel     = cdfa_pkg::cdfa_sel_t'(s_tuser[4:2]);
    assign address = s_tdata[cdfa_pkg::ADDR_W-1:0];
    assign value   = s_tdata[cdfa_pkg::ADDR_W +: cdfa_pkg::VALUE_W];
    assign in_xfer = s_tvalid && s_tready;
    assign tab_wr  = in_xfer && (op == cdfa_pkg::OP_WR_TABLE);

    // Address range checks
    assign addr_in_states = {1'b0, address} < (cdfa_pkg::ADDR_W + 1)'(cdfa_pkg::NUM_STATES);
    assign addr_in_table  = {1'b0, address} < (cdfa_pkg::ADDR_W + 1)'(cdfa_pkg::TABLE_DEPTH);
    assign addr_in_line   = {1'b0, address} < (cdfa_pkg::ADDR_W + 1)'(cdfa_pkg::LINE_DEPTH);

    // Write decode
    always_comb
    begin
        base_we  = 1'b0;
        check_we = 1'b0;
        next_we  = 1'b0;
        dflt_we  = 1'b0;
        acc_we   = 1'b0;
        unique case (sel)
            cdfa_pkg::SEL_BASE:    base_we  = tab_wr && addr_in_states;
            cdfa_pkg::SEL_CHECK:   check_we = tab_wr && addr_in_table;
            cdfa_pkg::SEL_NEXT:    next_we  = tab_wr && addr_in_table;
            cdfa_pkg::SEL_DEFAULT: dflt_we  = tab_wr && addr_in_states;
            cdfa_pkg::SEL_ACCEPT:  acc_we   = tab_wr && addr_in_states;
            default:
            begin
                base_we = 1'b0;
            end
        endcase
    end

    assign line_we = in_xfer && (op == cdfa_pkg::OP_WR_LINE) && addr_in_line;

    // Table and line memories
    cdfa_ram #(.WIDTH(cdfa_pkg::BASE_W), .DEPTH(cdfa_pkg::NUM_STATES)) u_base (
        .clk   (clk),
        .we    (base_we),
        .waddr (address[cdfa_pkg::STATE_AW-1:0]),
        .wdata (value[cdfa_pkg::BASE_W-1:0]),
        .re    (req.state_re),
        .raddr (req.state_addr),
        .rdata (rd.base)
    );

    cdfa_ram #(.WIDTH(cdfa_pkg::ENTRY_W), .DEPTH(cdfa_pkg::NUM_STATES)) u_dflt (
        .clk   (clk),
        .we    (dflt_we),
        .waddr (address[cdfa_pkg::STATE_AW-1:0]),
        .wdata (value[cdfa_pkg::ENTRY_W-1:0]),
        .re    (req.state_re),
        .raddr (req.state_addr),
        .rdata (rd.dflt)
    );

    cdfa_ram #(.WIDTH(cdfa_pkg::ENTRY_W), .DEPTH(cdfa_pkg::NUM_STATES)) u_acc (
        .clk   (clk),
        .we    (acc_we),
        .waddr (address[cdfa_pkg::STATE_AW-1:0]),
        .wdata (value[cdfa_pkg::ENTRY_W-1:0]),
        .re    (req.acc_re),
        .raddr (req.acc_addr),
        .rdata (rd.acc)
    );

    cdfa_ram #(.WIDTH(cdfa_pkg::ENTRY_W), .DEPTH(cdfa_pkg::TABLE_DEPTH)) u_check (
        .clk   (clk),
        .we    (check_we),
        .waddr (address[cdfa_pkg::TAB_AW-1:0]),
        .wdata (value[cdfa_pkg::ENTRY_W-1:0]),
        .re    (req.tab_re),
        .raddr (req.tab_addr),
        .rdata (rd.check)
    );

    cdfa_ram #(.WIDTH(cdfa_pkg::ENTRY_W), .DEPTH(cdfa_pkg::TABLE_DEPTH)) u_next (
        .clk   (clk),
        .we    (next_we),
        .waddr (address[cdfa_pkg::TAB_AW-1:0]),
        .wdata (value[cdfa_pkg::ENTRY_W-1:0]),
        .re    (req.tab_re),
        .raddr (req.tab_addr),
        .rdata (rd.nxt)
    );

    cdfa_ram #(.WIDTH(cdfa_pkg::CHAR_W), .DEPTH(cdfa_pkg::LINE_DEPTH)) u_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (address[cdfa_pkg::LINE_AW-1:0]),
        .wdata (value[cdfa_pkg::CHAR_W-1:0]),
        .re    (req.line_re),
        .raddr (req.line_addr),
        .rdata (rd.line)
    );

    // Scan sequencer
    cdfa_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_start (in_xfer && (op == cdfa_pkg::OP_SCAN)),
        .pos_we     (in_xfer && (op == cdfa_pkg::OP_SET_POS)),
        .pos_value  (value),
        .rd         (rd),
        .res_ack    (res_ack),
        .idle       (seq_idle),
        .req        (req),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign s_tready = seq_idle;
    assign res_ack  = res_valid && (!out_valid_reg || m_tready);

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ack)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.found;
    assign m_tdata  = {6'b0, out_reg.resume, out_reg.length, out_reg.start, out_reg.id};

endmodule

FILE: rtl/cdfa_checker.sv
// Port-level checker for the DFA scanner, bound to the top level.
`include "comb_table_dfa_scanner_defines.svh"

module cdfa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [4:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled result holds steady
    `CDFA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // A scan transfer makes the block busy in the next cycle
    `CDFA_ASSERT_NEXT(a_scan_busy, s_tvalid && s_tready && (s_tuser[1:0] == cdfa_pkg::OP_SCAN), !s_tready, "ready stayed high after a scan transfer")

    // Write and position-set transfers leave the block ready in the next cycle
    `CDFA_ASSERT_NEXT(a_write_quick, s_tvalid && s_tready && (s_tuser[1:0] != cdfa_pkg::OP_SCAN), s_tready, "ready dropped after a write transfer")

    // A miss reports id 0 and length 1
    `CDFA_ASSERT_SAME(a_miss_fields, m_tvalid && !m_tuser[0], (m_tdata[7:0] == 8'd0) && (m_tdata[24:16] == 9'd1), "miss result with nonzero id or length")

    // The resume position never passes the end of the line
    `CDFA_ASSERT_SAME(a_resume_range, m_tvalid, m_tdata[33:25] <= 9'(cdfa_pkg::LINE_DEPTH), "resume position past end of line")

endmodule

bind comb_table_dfa_scanner cdfa_checker u_cdfa_checker (.*);
